/* hdl/ifa_pkg.sv */
// Package with opcodes, pipeline types and constants for the folding ALU.
`timescale 1ns / 1ps
`default_nettype none
package ifa_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW = 5;
  localparam int unsigned DivStages = 32;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_REM = 5'd4,
    OP_SHL = 5'd5, OP_SHR = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
    OP_EQ = 5'd10, OP_NE = 5'd11, OP_UGT = 5'd12, OP_UGE = 5'd13,
    OP_ULT = 5'd14, OP_ULE = 5'd15, OP_SGT = 5'd16, OP_SGE = 5'd17,
    OP_SLT = 5'd18, OP_SLE = 5'd19
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] a;
    logic             fast_div;
    logic             neg_q;
    logic             neg_r;
    logic [WordW-1:0] fast;
  } side_t;
endpackage
`default_nettype wire

/* hdl/ifa_front.sv */
// Front stage: decodes the beat, computes simple results and divider operands.
`timescale 1ns / 1ps
`default_nettype none
module ifa_front import ifa_pkg::*; (
  input  wire logic [OpW-1:0]   op,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  input  wire logic             uns,
  output side_t                 side,
  output logic [WordW-1:0]      div_n,
  output logic [WordW-1:0]      div_d
);
  logic sgn;
  logic [WordW-1:0] sa, sb, r;
  logic [4:0] s;
  assign sgn = ~uns;
  assign sa = a ^ {1'b1, {(WordW-1){1'b0}}};
  assign sb = b ^ {1'b1, {(WordW-1){1'b0}}};
  assign s = b[4:0];
  always_comb begin
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_SHL: r = a << s;
      OP_SHR: r = uns ? (a >> s) : WordW'($signed(a) >>> s);
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_EQ:  r = WordW'(a == b);
      OP_NE:  r = WordW'(a != b);
      OP_UGT: r = WordW'(a > b);
      OP_UGE: r = WordW'(a >= b);
      OP_ULT: r = WordW'(a < b);
      OP_ULE: r = WordW'(a <= b);
      OP_SGT: r = WordW'(sa > sb);
      OP_SGE: r = WordW'(sa >= sb);
      OP_SLT: r = WordW'(sa < sb);
      OP_SLE: r = WordW'(sa <= sb);
      OP_DIV: r = a;
      default: r = '0;
    endcase
  end
  assign div_n = (sgn && a[WordW-1]) ? -a : a;
  assign div_d = (sgn && b[WordW-1]) ? -b : b;
  always_comb begin
    side.op = op;
    side.a = a;
    side.fast = r;
    side.fast_div = (b == '0);
    side.neg_q = sgn && (a[WordW-1] ^ b[WordW-1]);
    side.neg_r = sgn && a[WordW-1];
  end
endmodule
`default_nettype wire

/* hdl/ifa_mul.sv */
// Pipelined 32x32 multiplier built from three 16x16 partial products.
`timescale 1ns / 1ps
`default_nettype none
module ifa_mul import ifa_pkg::*; #(
  parameter int unsigned Lat = 34
) (
  input  wire logic             clk,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  output logic [WordW-1:0]      p
);
  logic [WordW-1:0] ll_r;
  logic [15:0] lh_r, hl_r;
  logic [WordW-1:0] sum_r;
  logic [WordW-1:0] dly_r [Lat-2];
  always_ff @(posedge clk) begin
    ll_r <= a[15:0] * b[15:0];
    lh_r <= a[15:0] * b[31:16];
    hl_r <= a[31:16] * b[15:0];
    sum_r <= ll_r + {lh_r + hl_r, 16'h0000};
    dly_r[0] <= sum_r;
    for (int i = 1; i < Lat - 2; i++) dly_r[i] <= dly_r[i-1];
  end
  assign p = dly_r[Lat-3];
endmodule
`default_nettype wire

/* hdl/ifa_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ifa_div import ifa_pkg::*; (
  input  wire logic             clk,
  input  wire logic [WordW-1:0] n,
  input  wire logic [WordW-1:0] d,
  output logic [WordW-1:0]      q,
  output logic [WordW-1:0]      r
);
  logic [WordW-1:0] q_r [DivStages+1];
  logic [WordW-1:0] r_r [DivStages+1];
  logic [WordW-1:0] d_r [DivStages+1];
  always_ff @(posedge clk) begin
    q_r[0] <= n;
    r_r[0] <= '0;
    d_r[0] <= d;
    for (int i = 0; i < DivStages; i++) begin
      logic [WordW:0] t;
      t = {r_r[i], q_r[i][WordW-1]};
      if (t >= {1'b0, d_r[i]}) begin
        r_r[i+1] <= WordW'(t - {1'b0, d_r[i]});
        q_r[i+1] <= {q_r[i][WordW-2:0], 1'b1};
      end else begin
        r_r[i+1] <= t[WordW-1:0];
        q_r[i+1] <= {q_r[i][WordW-2:0], 1'b0};
      end
      d_r[i+1] <= d_r[i];
    end
  end
  assign q = q_r[DivStages];
  assign r = r_r[DivStages];
endmodule
`default_nettype wire

/* hdl/int32_fold_alu_unit.sv */
// Top level of the pipelined 32-bit folding ALU.
//  channel | direction | handshake           | payload
//  in      | input     | start, busy         | in_req_type, in_operand_a/b, in_is_unsigned
//  out     | output    | out_valid (strobe)  | out_result
// Every beat passes from its accepting edge to the edge that takes its result
// through the divider input register, 32 divider stages (one quotient bit each)
// and the output register; all opcodes share that path depth so results leave in
// order. One beat per cycle.
// busy is always low. Reset clears only the valid bits. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module int32_fold_alu_unit import ifa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [OpW-1:0]   in_req_type,
  input  wire logic [WordW-1:0] in_operand_a,
  input  wire logic [WordW-1:0] in_operand_b,
  input  wire logic             in_is_unsigned,
  output logic                  out_valid,
  output logic [WordW-1:0]      out_result
);
  localparam int unsigned Depth = DivStages + 1;
  side_t side;
  side_t side_r [Depth];
  logic [Depth-1:0] vld_r;
  logic [WordW-1:0] dn, dd, q, r, p, res_nxt, res_r, qs, rs;
  logic out_valid_r;

  assign busy = 1'b0;
  ifa_front u_front (.op(in_req_type), .a(in_operand_a), .b(in_operand_b),
    .uns(in_is_unsigned), .side(side), .div_n(dn), .div_d(dd));
  ifa_div u_div (.clk(clk), .n(dn), .d(dd), .q(q), .r(r));
  ifa_mul #(.Lat(Depth)) u_mul (.clk(clk), .a(in_operand_a), .b(in_operand_b), .p(p));

  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < Depth; i++) side_r[i] <= side_r[i-1];
    res_r <= res_nxt;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[Depth-2:0], start};
      out_valid_r <= vld_r[Depth-1];
    end
  end

  assign qs = side_r[Depth-1].neg_q ? -q : q;
  assign rs = side_r[Depth-1].neg_r ? -r : r;
  always_comb begin
    case (side_r[Depth-1].op)
      OP_MUL: res_nxt = p;
      OP_DIV: res_nxt = side_r[Depth-1].fast_div ? side_r[Depth-1].a : qs;
      OP_REM: res_nxt = side_r[Depth-1].fast_div ? '0 : rs;
      default: res_nxt = side_r[Depth-1].fast;
    endcase
  end
  assign out_valid = out_valid_r;
  assign out_result = res_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##34 out_valid) else $error("beat lost in pipeline");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '0 && !start) |=> ##1 !out_valid) else $error("result without beat");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule
`default_nettype wire

/* tb/int32_fold_alu_unit_tb.sv */
// Testbench for the pipelined 32-bit folding ALU: directed and random beats against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module int32_fold_alu_unit_tb;
  import ifa_pkg::*;

  localparam int Latency = 34;
  localparam int CycleLimit = 200000;
  localparam logic [4:0] OpUnknown = 5'd20;
  localparam logic [4:0] OpUnknownTop = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OpW-1:0] in_req_type = '0;
  logic [WordW-1:0] in_operand_a = '0;
  logic [WordW-1:0] in_operand_b = '0;
  logic in_is_unsigned = 1'b0;
  logic out_valid;
  logic [WordW-1:0] out_result;

  logic [31:0] expected_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;

  int32_fold_alu_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .in_is_unsigned(in_is_unsigned),
    .out_valid(out_valid), .out_result(out_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] alu_value(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                            logic uns);
    logic [31:0] ma, mb, q, r;
    logic [4:0] sh;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    sh = b[4:0];
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 0) return a;
        if (uns) return a / b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
      OP_REM: begin
        if (b == 0) return 0;
        if (uns) return a % b;
        r = ma % mb;
        return a[31] ? -r : r;
      end
      OP_SHL: return a << sh;
      OP_SHR: return uns ? a >> sh : $unsigned($signed(a) >>> sh);
      OP_AND: return a & b;
      OP_OR:  return a | b;
      OP_XOR: return a ^ b;
      OP_EQ:  return {31'd0, a == b};
      OP_NE:  return {31'd0, a != b};
      OP_UGT: return {31'd0, a > b};
      OP_UGE: return {31'd0, a >= b};
      OP_ULT: return {31'd0, a < b};
      OP_ULE: return {31'd0, a <= b};
      OP_SGT: return {31'd0, $signed(a) > $signed(b)};
      OP_SGE: return {31'd0, $signed(a) >= $signed(b)};
      OP_SLT: return {31'd0, $signed(a) < $signed(b)};
      OP_SLE: return {31'd0, $signed(a) <= $signed(b)};
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: result %h", out_result);
      end else begin
        logic [31:0] want;
        want = expected_results.pop_front();
        if (out_result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, got %h", want, out_result);
        end
      end
    end
  end

  task automatic note_expected(logic [31:0] value);
    expected_results.insert(expected_results.size(), value);
  endtask

  task automatic send_beat(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic uns);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_is_unsigned <= uns;
    @(posedge clk);
    while (busy) @(posedge clk);
    note_expected(alu_value(op, a, b, uns));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_beat(OP_ADD, mx, 32'd1, 1'b0);
    send_beat(OP_SUB, mn, 32'd1, 1'b1);
    send_beat(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_beat(OP_DIV, 32'd77, 32'd0, 1'b0);
    send_beat(OP_REM, 32'd77, 32'd0, 1'b1);
    send_beat(OP_DIV, mn, 32'hffff_ffff, 1'b0);
    send_beat(OP_REM, mn, 32'hffff_ffff, 1'b0);
    send_beat(OP_DIV, 32'hffff_fff9, 32'd2, 1'b0);
    send_beat(OP_REM, 32'hffff_fff9, 32'd2, 1'b0);
    send_beat(OP_DIV, 32'hffff_fff9, 32'd2, 1'b1);
    send_beat(OP_SHL, 32'h1, 32'hffff_ffff, 1'b0);
    send_beat(OP_SHR, mn, 32'd63, 1'b0);
    send_beat(OP_SHR, mn, 32'd63, 1'b1);
    send_beat(OP_AND, mx, mn, 1'b0);
    send_beat(OP_OR, mx, mn, 1'b0);
    send_beat(OP_XOR, mx, 32'hffff_ffff, 1'b0);
    for (int op = OP_EQ; op <= OP_SLE; op++) send_beat(5'(op), mn, mx, op[0]);
    send_beat(OpUnknown, mx, mx, 1'b1);
    send_beat(OpUnknownTop, mn, mn, 1'b0);
    drain();
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(2) - 1;
      1: return $urandom_range(3) - 1;
      2: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++)
      send_beat(5'($urandom_range(31)), random_operand(), random_operand(), 1'($urandom));
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(340, 33);
    test_random(340, 61);
    test_random(340, 0);
    repeat (Latency + 5) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hdl/ifa_pkg.sv
hdl/ifa_front.sv
hdl/ifa_mul.sv
hdl/ifa_div.sv
hdl/int32_fold_alu_unit.sv
tb/int32_fold_alu_unit_tb.sv
